/* rtl/core/fpd_pkg.sv */
// shared types and constants for the flight phase detector
`timescale 1ns / 1ps

package fpd_pkg;

	localparam int HIST_DEPTH = 5;
	localparam int ALT_W      = 18;
	localparam int CFG_W      = 17;
	localparam int FRAC_W     = 8;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(4);

	typedef enum logic [2:0] {
		PH_PAD     = 3'd0,
		PH_ASCENT  = 3'd1,
		PH_APOGEE  = 3'd2,
		PH_DESCENT = 3'd3,
		PH_RELEASE = 3'd4,
		PH_LANDED  = 3'd5,
		PH_IDLE    = 3'd6
	} phase_t;

	// load value that leaves the phase untouched
	localparam logic [2:0] PH_NONE = 3'd7;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_EVAL  = 2'd1,
		CMD_LOAD  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_RISE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_CEILING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REL_FRACTION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LANDED_LEVEL = 3'd5;

	localparam logic [CFG_W-1:0]  RST_LAUNCH_RISE  = CFG_W'(160);
	localparam logic [CFG_W-1:0]  RST_DROP_STEP    = CFG_W'(160);
	localparam logic [CFG_W-1:0]  RST_JUMP_LIMIT   = CFG_W'(320);
	localparam logic [CFG_W-1:0]  RST_PEAK_CEILING = CFG_W'(16000);
	localparam logic [FRAC_W-1:0] RST_REL_FRACTION = FRAC_W'(192);
	localparam logic [CFG_W-1:0]  RST_LANDED_LEVEL = CFG_W'(80);

endpackage

/* rtl/core/flight_phase_detector.sv */
// flight phase detector top level: sample window, peak tracking and phase steps
`timescale 1ns / 1ps

// Takes one transaction per cycle on the input channel (cmd, altitude, load_value) and
// returns exactly one result transaction for each, in order. A transaction is captured in an
// input register; when the output register can take it, the window shift, peak update and
// phase decision are done in a single pass of logic, state is updated and the result lands in
// the output register. The sustained rate is one transaction per cycle; the only stall comes
// from the output side holding out_ready low.
// The release test uses one 9x18 multiply of the peak by the release fraction.
// Configuration writes are always ready and must only occur while the block is idle.
module flight_phase_detector
	import fpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic signed [ALT_W-1:0] altitude,
	input  logic [2:0]            load_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            phase,
	output logic                  phase_changed,
	output logic                  release_fire,
	output logic signed [ALT_W-1:0] peak_out
);

	// configuration registers
	logic [CFG_W-1:0]  launch_rise_q, drop_step_q, jump_limit_q, peak_ceiling_q, landed_level_q;
	logic [FRAC_W-1:0] rel_fraction_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_rise_q  <= RST_LAUNCH_RISE;
			drop_step_q    <= RST_DROP_STEP;
			jump_limit_q   <= RST_JUMP_LIMIT;
			peak_ceiling_q <= RST_PEAK_CEILING;
			rel_fraction_q <= RST_REL_FRACTION;
			landed_level_q <= RST_LANDED_LEVEL;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LAUNCH_RISE:  launch_rise_q  <= cfg_data;
				REG_DROP_STEP:    drop_step_q    <= cfg_data;
				REG_JUMP_LIMIT:   jump_limit_q   <= cfg_data;
				REG_PEAK_CEILING: peak_ceiling_q <= cfg_data;
				REG_REL_FRACTION: rel_fraction_q <= cfg_data[FRAC_W-1:0];
				REG_LANDED_LEVEL: landed_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic signed [ALT_W-1:0] alt_s1;
	logic [2:0]              load_s1;
	logic                    advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd_t'(cmd);
			alt_s1  <= altitude;
			load_s1 <= load_value;
		end
	end

	// block state
	logic signed [ALT_W-1:0] hist_q [HIST_DEPTH];
	logic signed [ALT_W-1:0] peak_q;
	logic [CNT_W-1:0]        count_q;
	phase_t                  phase_q;

	// next-state logic
	logic signed [ALT_W-1:0] hist_win [HIST_DEPTH];
	logic signed [ALT_W-1:0] hist_d [HIST_DEPTH];
	logic signed [ALT_W-1:0] peak_win, peak_d;
	logic [CNT_W-1:0]        count_win, count_d;
	phase_t                  eval_phase, phase_d;
	logic                    eval_fire, fire_d;

	logic signed [ALT_W+1:0] n0, n1, n2, n3, n4;
	logic signed [ALT_W+1:0] hi01, diff10, abs10, drop_s, jump_s, rise_s, ceil_s;
	logic                    falling3;
	logic signed [ALT_W+1:0] sum3;
	logic signed [ALT_W+2:0] sum5;
	logic signed [ALT_W+2:0] landed5;
	logic signed [ALT_W+8:0] frac_prod;
	logic signed [ALT_W+11:0] rel_lhs, rel_rhs;

	always_comb begin
		for (int i = 0; i < HIST_DEPTH; i++) begin
			hist_win[i] = hist_q[i];
		end
		count_win = count_q;
		if (cmd_s1 == CMD_PUSH) begin
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				hist_win[i] = hist_q[i-1];
			end
			hist_win[0] = alt_s1;
			if (count_q < CNT_FULL) count_win = count_q + CNT_W'(1);
		end
	end

	assign n0 = (ALT_W+2)'(hist_win[0]);
	assign n1 = (ALT_W+2)'(hist_win[1]);
	assign n2 = (ALT_W+2)'(hist_win[2]);
	assign n3 = (ALT_W+2)'(hist_win[3]);
	assign n4 = (ALT_W+2)'(hist_win[4]);

	assign drop_s = $signed({3'b000, drop_step_q});
	assign jump_s = $signed({3'b000, jump_limit_q});
	assign rise_s = $signed({3'b000, launch_rise_q});
	assign ceil_s = $signed({3'b000, peak_ceiling_q});

	// peak tracking only raises the peak outside descent, and never to a sample at or above the ceiling
	always_comb begin
		peak_win = peak_q;
		if (phase_q != PH_DESCENT && n0 > (ALT_W+2)'(peak_q) && n0 < ceil_s) begin
			peak_win = hist_win[0];
		end
	end

	assign hi01     = (n0 > n1) ? n0 : n1;
	assign diff10   = n1 - n0;
	assign abs10    = diff10[ALT_W+1] ? -diff10 : diff10;
	assign falling3 = (n2 > n1) && (n1 > n0) && ((n2 - n0) > drop_s);

	assign sum3      = n0 + n1 + n2;
	assign sum5      = (ALT_W+3)'(n0) + (ALT_W+3)'(n1) + (ALT_W+3)'(n2)
	                 + (ALT_W+3)'(n3) + (ALT_W+3)'(n4);
	assign landed5   = $signed({2'b00, landed_level_q, 1'b0, 1'b0})
	                 + $signed({4'b0000, landed_level_q});
	// peak tracking does not move the peak in descent, so the stored peak is the one to compare against
	assign frac_prod = (ALT_W+9)'($signed({1'b0, rel_fraction_q})) * (ALT_W+9)'(peak_q);
	assign rel_lhs   = (ALT_W+12)'(sum3) <<< 8;
	assign rel_rhs   = ((ALT_W+12)'(frac_prod) <<< 1) + (ALT_W+12)'(frac_prod);

	always_comb begin
		eval_phase = phase_q;
		eval_fire  = 1'b0;
		case (phase_q)
			PH_PAD: begin
				if (count_win >= CNT_FULL && hi01 > rise_s) eval_phase = PH_ASCENT;
			end
			PH_ASCENT: begin
				if (n0 < n1 - drop_s && abs10 < jump_s) eval_phase = PH_APOGEE;
				else if (falling3) eval_phase = PH_DESCENT;
			end
			PH_APOGEE: begin
				if (falling3) eval_phase = PH_DESCENT;
			end
			PH_DESCENT: begin
				if (rel_lhs <= rel_rhs) begin
					eval_phase = PH_RELEASE;
					eval_fire  = 1'b1;
				end
			end
			PH_RELEASE: begin
				if (sum5 < landed5) eval_phase = PH_PAD;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < HIST_DEPTH; i++) begin
			hist_d[i] = hist_q[i];
		end
		peak_d  = peak_q;
		count_d = count_q;
		phase_d = phase_q;
		fire_d  = 1'b0;
		case (cmd_s1)
			CMD_PUSH, CMD_EVAL: begin
				for (int i = 0; i < HIST_DEPTH; i++) begin
					hist_d[i] = hist_win[i];
				end
				peak_d  = peak_win;
				count_d = count_win;
				phase_d = eval_phase;
				fire_d  = eval_fire;
			end
			CMD_LOAD: begin
				if (load_s1 != PH_NONE) phase_d = phase_t'(load_s1);
			end
			CMD_CLEAR: begin
				for (int i = 0; i < HIST_DEPTH; i++) begin
					hist_d[i] = '0;
				end
				peak_d  = '0;
				count_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			peak_q  <= '0;
			count_q <= '0;
			phase_q <= PH_PAD;
		end else if (advance) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_d[i];
			end
			peak_q  <= peak_d;
			count_q <= count_d;
			phase_q <= phase_d;
		end
	end

	// result register
	phase_t                  phase_s2;
	logic                    changed_s2, fire_s2;
	logic signed [ALT_W-1:0] peak_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2   <= phase_d;
			changed_s2 <= (phase_d != phase_q);
			fire_s2    <= fire_d;
			peak_s2    <= peak_d;
		end
	end

	assign phase         = phase_s2;
	assign phase_changed = changed_s2;
	assign release_fire  = fire_s2;
	assign peak_out      = peak_s2;

endmodule
